// File: rtl/cc20_pkg.sv
// Package for the ChaCha20 byte stream cipher: payload structs, sigma constants,
// configuration register indexes and the quarter round function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cc20_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       message_end;
	} in_word_t;

	typedef struct packed {
		logic [7:0] result_byte;
		logic       result_end;
	} out_word_t;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646E;
	localparam logic [31:0] SIGMA2 = 32'h79622D32;
	localparam logic [31:0] SIGMA3 = 32'h6B206574;

	localparam logic [2:0] REG_KEY0  = 3'd0;
	localparam logic [2:0] REG_KEY1  = 3'd1;
	localparam logic [2:0] REG_KEY2  = 3'd2;
	localparam logic [2:0] REG_KEY3  = 3'd3;
	localparam logic [2:0] REG_NONCE = 3'd4;

	typedef logic [15:0][31:0] state_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} qr_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

	function automatic qr_t quarter(input qr_t v);
		qr_t r;
		r = v;
		r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 16);
		r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 12);
		r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 8);
		r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 7);
		quarter = r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/chacha20_stream_cipher.sv
// ChaCha20 byte stream cipher (64-bit nonce, 64-bit counter), top level.
// Mid-block, a word passes through the input queue and the output register; a word
// at a block start also waits for the block function, which does one column or
// diagonal round a cycle. One word a cycle within a block unless out_ready stalls.
// Reset (arst_n low) clears key, nonce, counter, byte position and the queue.
// Depends on cc20_pkg, cc20_front, cc20_back.
`timescale 1ns / 1ps
`default_nettype none
module chacha20_stream_cipher #(
	parameter int DOUBLE_ROUND_COUNT = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire cc20_pkg::in_word_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output cc20_pkg::out_word_t       out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [63:0]         cfg_data
);
	logic [3:0][63:0] key_q;
	logic [63:0] nonce_q;
	logic q_valid, q_pop;
	cc20_pkg::in_word_t q_data;
	logic [5:0] q_pos;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			nonce_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cc20_pkg::REG_KEY0:  key_q[0] <= cfg_data;
				cc20_pkg::REG_KEY1:  key_q[1] <= cfg_data;
				cc20_pkg::REG_KEY2:  key_q[2] <= cfg_data;
				cc20_pkg::REG_KEY3:  key_q[3] <= cfg_data;
				cc20_pkg::REG_NONCE: nonce_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cc20_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
		.q_pos(q_pos)
	);

	cc20_back #(.DOUBLE_ROUND_COUNT(DOUBLE_ROUND_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_data(q_data), .q_pos(q_pos), .key(key_q), .nonce(nonce_q),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule
`default_nettype wire

// File: rtl/cc20_front.sv
// Front end: takes input words into a short queue and tags each with its
// position in the keystream block. Depends on cc20_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cc20_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire cc20_pkg::in_word_t in_data,
	output logic                   q_valid,
	input  wire logic              q_pop,
	output cc20_pkg::in_word_t      q_data,
	output logic [5:0]             q_pos
);
	cc20_pkg::in_word_t mem_q [4];
	logic [5:0] pos_mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic [5:0] pos_q;
	logic push;

	assign in_ready = (cnt_q != 3'd4);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 3'd0);
	assign q_data = mem_q[rd_q];
	assign q_pos = pos_mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
			pos_mem_q[wr_q] <= pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			pos_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 2'd1;
				// restart the block after the last word of a message
				pos_q <= in_data.message_end ? 6'd0 : pos_q + 6'd1;
			end
			if (q_pop)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

// File: rtl/cc20_core.sv
// Block function: one double round half (column or diagonal) per cycle,
// then the feed-forward add. Depends on cc20_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cc20_core #(
	parameter int DOUBLE_ROUND_COUNT = 10
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire cc20_pkg::state_t init,
	output logic                 busy,
	output logic                 done,
	output cc20_pkg::state_t      block
);
	localparam int HALF_ROUNDS = 2 * DOUBLE_ROUND_COUNT;
	localparam int CW = $clog2(HALF_ROUNDS + 1);

	cc20_pkg::state_t w_q, init_q, nxt;
	logic [CW-1:0] cnt_q;
	logic run_q;

	always_comb begin
		cc20_pkg::qr_t r;
		nxt = w_q;
		for (int i = 0; i < 4; i++) begin
			if (!cnt_q[0]) begin
				r = cc20_pkg::quarter({w_q[i], w_q[4+i], w_q[8+i], w_q[12+i]});
				nxt[i] = r.a; nxt[4+i] = r.b; nxt[8+i] = r.c; nxt[12+i] = r.d;
			end else begin
				r = cc20_pkg::quarter({w_q[i], w_q[4+((i+1)%4)],
					w_q[8+((i+2)%4)], w_q[12+((i+3)%4)]});
				nxt[i] = r.a; nxt[4+((i+1)%4)] = r.b;
				nxt[8+((i+2)%4)] = r.c; nxt[12+((i+3)%4)] = r.d;
			end
		end
	end

	assign busy = run_q;

	always_ff @(posedge clk) begin
		if (start) begin
			w_q <= init;
			init_q <= init;
		end else if (run_q && cnt_q != CW'(HALF_ROUNDS)) begin
			w_q <= nxt;
		end
		if (run_q && cnt_q == CW'(HALF_ROUNDS))
			for (int i = 0; i < 16; i++)
				block[i] <= w_q[i] + init_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CW'(HALF_ROUNDS)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/cc20_back.sv
// Back end: pops tagged words, makes a keystream block at position zero and
// XORs one keystream byte per word into the output register. Depends on
// cc20_pkg and cc20_core.
`timescale 1ns / 1ps
`default_nettype none
module cc20_back #(
	parameter int DOUBLE_ROUND_COUNT = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	output logic                    q_pop,
	input  wire cc20_pkg::in_word_t  q_data,
	input  wire logic [5:0]         q_pos,
	input  wire logic [3:0][63:0]   key,
	input  wire logic [63:0]        nonce,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output cc20_pkg::out_word_t      out_data
);
	typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT} st_t;
	st_t st_q;
	logic [63:0] ctr_q;
	logic have_q;
	cc20_pkg::state_t init, block;
	logic busy, done, start, slot;
	logic [7:0] ks;

	assign init = {nonce[63:32], nonce[31:0], ctr_q[63:32], ctr_q[31:0],
		key[3][63:32], key[3][31:0], key[2][63:32], key[2][31:0],
		key[1][63:32], key[1][31:0], key[0][63:32], key[0][31:0],
		cc20_pkg::SIGMA3, cc20_pkg::SIGMA2, cc20_pkg::SIGMA1, cc20_pkg::SIGMA0};

	assign start = (st_q == S_START);
	assign slot = !out_valid || out_ready;
	// a word at position zero needs a fresh block first
	assign q_pop = q_valid && slot && st_q == S_IDLE && (q_pos != 6'd0 || have_q);
	assign ks = block[q_pos[5:2]][8*q_pos[1:0] +: 8];

	cc20_core #(.DOUBLE_ROUND_COUNT(DOUBLE_ROUND_COUNT)) u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .init(init),
		.busy(busy), .done(done), .block(block)
	);

	always_ff @(posedge clk) begin
		if (q_pop)
			out_data <= '{result_byte: q_data.data_byte ^ ks,
				result_end: q_data.message_end};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ctr_q <= '0;
			have_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (q_pop)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (q_valid && q_pos == 6'd0 && !have_q)
						st_q <= S_START;
				end
				S_START: st_q <= S_WAIT;
				S_WAIT: begin
					if (done && !busy) begin
						st_q <= S_IDLE;
						have_q <= 1'b1;
						ctr_q <= ctr_q + 64'd1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
			if (q_pop) begin
				if (q_data.message_end)
					ctr_q <= '0;
				// drop the block once its last byte or the message is used
				if (q_data.message_end || q_pos == 6'd63)
					have_q <= 1'b0;
				else if (q_pos == 6'd0)
					have_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// File: sim/chacha20_stream_cipher_tb.sv
// Self-checking testbench for chacha20_stream_cipher: drives bytes and key/nonce writes,
// predicts each result byte with its own ChaCha20 keystream model and compares in order.
// Depends on cc20_pkg and the chacha20_stream_cipher RTL.
`timescale 1ns / 1ps
`default_nettype none

class cipher_scoreboard;
	bit [63:0]   key_reg [4];
	bit [63:0]   nonce_reg;
	bit [63:0]   blk_ctr;
	bit [5:0]    pos;
	bit [7:0]    ks [64];
	cc20_pkg::out_word_t pending [$];
	int          errors;
	int          checked;

	function void clear();
		foreach (key_reg[i]) key_reg[i] = '0;
		nonce_reg = '0;
		blk_ctr = '0;
		pos = '0;
		pending.delete();
	endfunction

	function void write_reg(bit [2:0] idx, bit [63:0] val);
		if (idx == cc20_pkg::REG_NONCE)
			nonce_reg = val;
		else if (idx < cc20_pkg::REG_NONCE)
			key_reg[idx] = val;
	endfunction

	function bit [31:0] rol(bit [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function void mix(ref bit [31:0] w [16], input int a, int b, int c, int d);
		w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 16);
		w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 12);
		w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 8);
		w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 7);
	endfunction

	function void next_keystream();
		bit [31:0] st [16];
		bit [31:0] w [16];
		bit [31:0] v;
		st[0] = cc20_pkg::SIGMA0; st[1] = cc20_pkg::SIGMA1;
		st[2] = cc20_pkg::SIGMA2; st[3] = cc20_pkg::SIGMA3;
		for (int i = 0; i < 4; i++) begin
			st[4 + 2 * i] = key_reg[i][31:0];
			st[5 + 2 * i] = key_reg[i][63:32];
		end
		st[12] = blk_ctr[31:0]; st[13] = blk_ctr[63:32];
		st[14] = nonce_reg[31:0]; st[15] = nonce_reg[63:32];
		w = st;
		for (int r = 0; r < 10; r++) begin
			mix(w, 0, 4, 8, 12); mix(w, 1, 5, 9, 13);
			mix(w, 2, 6, 10, 14); mix(w, 3, 7, 11, 15);
			mix(w, 0, 5, 10, 15); mix(w, 1, 6, 11, 12);
			mix(w, 2, 7, 8, 13); mix(w, 3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++) begin
			v = w[i] + st[i];
			for (int b = 0; b < 4; b++) ks[4 * i + b] = v[8 * b +: 8];
		end
		blk_ctr += 1;
	endfunction

	function void note_input(cc20_pkg::in_word_t w);
		cc20_pkg::out_word_t e;
		if (pos == 0) next_keystream();
		e.result_byte = w.data_byte ^ ks[pos];
		e.result_end = w.message_end;
		pending.push_back(e);
		pos++;
		if (w.message_end) begin
			pos = '0;
			blk_ctr = '0;
		end
	endfunction

	function void check_result(cc20_pkg::out_word_t got);
		cc20_pkg::out_word_t e;
		checked++;
		if (pending.size() == 0) begin
			$error("unexpected result word %h", got);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.result_byte !== e.result_byte) begin
			$error("result_byte: expected %h, got %h", e.result_byte, got.result_byte);
			errors++;
		end
		if (got.result_end !== e.result_end) begin
			$error("result_end: expected %b, got %b", e.result_end, got.result_end);
			errors++;
		end
	endfunction
endclass

module chacha20_stream_cipher_tb;

	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	cc20_pkg::in_word_t  in_data;
	logic        out_valid;
	logic        out_ready;
	cc20_pkg::out_word_t out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	cipher_scoreboard sb;
	int          idle_cycles;
	int          bytes_sent;
	int          messages;
	bit          stall_mode;

	chacha20_stream_cipher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: check on accepted words, stall pattern changes mode now and then
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0)
			stall_mode = ~stall_mode;
		out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// drive at the falling edge; valid stays high across back-to-back words
	task automatic send_byte(input logic [7:0] b, input logic last);
		in_data = '{data_byte: b, message_end: last};
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_input('{data_byte: b, message_end: last});
		bytes_sent++;
		if (last) messages++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// n bytes in random bursts of 1 to 40 bytes; gaps only between bursts
	task automatic send_message(input int n, input bit rand_data);
		int burst;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
			burst--;
			send_byte(rand_data ? 8'($urandom) : 8'(i * 37), i == n - 1);
		end
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_cfg(input logic [2:0] idx, input logic [63:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_all(input logic [63:0] k0, k1, k2, k3, nc);
		write_cfg(cc20_pkg::REG_KEY0, k0);
		write_cfg(cc20_pkg::REG_KEY1, k1);
		write_cfg(cc20_pkg::REG_KEY2, k2);
		write_cfg(cc20_pkg::REG_KEY3, k3);
		write_cfg(cc20_pkg::REG_NONCE, nc);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		stall_mode = 1'b0;
		idle_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero key, single-byte messages at the field extremes, then a two-byte message
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b1);
		drain();
		// all-ones key and nonce; message crossing a block boundary
		load_all('1, '1, '1, '1, '1);
		send_message(70, 1'b0);
		drain();
		// out-of-range indexes must be ignored
		write_cfg(3'd5, rand64());
		write_cfg(3'd7, '1);
		load_all(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h1716151413121110,
			64'h1f1e1d1c1b1a1918, 64'h0000004a00000000);
		send_message(20, 1'b0);
		// pause the sender until every result is back
		drain();

		// random: mostly short messages, a few spanning several blocks
		while (bytes_sent < 630) begin
			if ($urandom_range(0, 3) == 0) begin
				drain();
				load_all(rand64(), rand64(), rand64(), rand64(), rand64());
			end
			if ($urandom_range(0, 9) == 0) begin
				drain();
				write_cfg(3'($urandom_range(0, 7)), rand64());
			end
			send_message($urandom_range(0, 7) == 0 ? $urandom_range(64, 200)
				: $urandom_range(1, 40), 1'b1);
			if ($urandom_range(0, 2) == 0) drain();
			else if ($urandom_range(0, 1) == 0) begin
				drain();
				load_all('0, '0, '0, '0, '0);
			end
		end
		drain();

		$display("Covered %0d bytes in %0d messages, %0d results checked,",
			bytes_sent, messages, sb.checked);
		$display("with key and nonce changes, block crossings and back-pressure.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

// File: chacha20_stream_cipher.f
rtl/cc20_pkg.sv
rtl/cc20_front.sv
rtl/cc20_core.sv
rtl/cc20_back.sv
rtl/chacha20_stream_cipher.sv
sim/chacha20_stream_cipher_tb.sv
